FILE: design/madt_pkg.sv
// Shared types, codes and helpers for the multiple-APIC table parser.
// Depends on nothing; every design file refers to it by scoped names.
package madt_pkg;

  // Header geometry.
  localparam int unsigned HDR_LEN = 44;

  // Entry type codes found in the table.
  localparam logic [7:0] TYPE_PROCESSOR     = 8'd0;
  localparam logic [7:0] TYPE_IOAPIC        = 8'd1;
  localparam logic [7:0] TYPE_OVERRIDE      = 8'd2;
  localparam logic [7:0] TYPE_LAPIC_ADDRESS = 8'd5;

  // Record kinds reported on the output channel.
  localparam logic [2:0] KIND_PROCESSOR = 3'd0;
  localparam logic [2:0] KIND_IOAPIC    = 3'd1;
  localparam logic [2:0] KIND_OVERRIDE  = 3'd2;
  localparam logic [2:0] KIND_DONE      = 3'd3;
  localparam logic [2:0] KIND_MALFORMED = 3'd4;

  // Record queue geometry.
  localparam int unsigned REC_DEPTH = 4;
  localparam int unsigned REC_PTR_W = $clog2(REC_DEPTH);
  localparam int unsigned REC_CNT_W = $clog2(REC_DEPTH + 1);

  typedef struct packed {
    logic [7:0] table_byte;
    logic       first_byte;
  } byte_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  ordinal;
    logic [7:0]  first_id;
    logic [7:0]  second_id;
    logic [63:0] address;
    logic [31:0] gsi;
    logic        last_of_run;
  } record_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic [31:0] table_length;
    logic [63:0] local_apic_base;
    logic        base_replaced;
    logic [7:0]  entry_offset;
    logic [7:0]  entry_type;
    logic [7:0]  entry_length;
    logic [7:0]  field_a;
    logic [7:0]  field_b;
    logic [63:0] field_address;
    logic [31:0] field_interrupt;
    logic [7:0]  processor_count;
    logic [7:0]  ioapic_total;
    logic [7:0]  override_count;
    logic        halted;
  } parse_state_t;

  // After reset every field but the halt flag is clear and the parser waits for a first byte.
  localparam parse_state_t PARSE_STATE_RESET = '{halted: 1'b1, default: '0};

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? 8'hFF : v + 8'd1;
  endfunction

endpackage

FILE: design/madt_step.sv
// Next-state and record logic for one table byte of the parser.
// Depends on madt_pkg for the state, byte and record types.
module madt_step (
  input  madt_pkg::parse_state_t st,
  input  madt_pkg::byte_t        data,
  output madt_pkg::parse_state_t st_next,
  output logic [1:0]             rec_count,
  output madt_pkg::record_t      rec0,
  output madt_pkg::record_t      rec1
);

  always_comb begin
    madt_pkg::parse_state_t cur;
    madt_pkg::parse_state_t nx;
    madt_pkg::record_t      ent_rec;
    madt_pkg::record_t      done_rec;
    logic                   ent_hit;
    logic                   malformed;
    logic [31:0]            p;
    logic [7:0]             b;
    logic [7:0]             eo;
    logic [7:0]             ai;

    cur = st;
    if (data.first_byte) begin
      cur = '0;
    end
    nx        = cur;
    b         = data.table_byte;
    p         = cur.byte_offset;
    eo        = cur.entry_offset;
    ai        = eo - 8'd4;
    ent_rec   = '0;
    done_rec  = '0;
    ent_hit   = 1'b0;
    malformed = 1'b0;
    rec_count = 2'd0;
    rec0      = '0;
    rec1      = '0;

    if (!cur.halted) begin
      if (p < madt_pkg::HDR_LEN) begin
        if (p >= 32'd4 && p < 32'd8) begin
          nx.table_length[{p[1:0], 3'b000} +: 8] = b;
        end else if (p >= 32'd36 && p < 32'd40) begin
          nx.local_apic_base[{p[1:0], 3'b000} +: 8] = b;
        end
      end else begin
        if (eo == 8'd0) begin
          nx.entry_type      = b;
          nx.entry_length    = '0;
          nx.field_a         = '0;
          nx.field_b         = '0;
          nx.field_address   = '0;
          nx.field_interrupt = '0;
        end else if (eo == 8'd1) begin
          nx.entry_length = b;
          malformed       = (b < 8'd2);
        end else begin
          if (eo == 8'd2) begin
            nx.field_a = b;
          end else if (eo == 8'd3) begin
            nx.field_b = b;
          end
          if (eo >= 8'd4 && eo < 8'd12) begin
            nx.field_address[{ai[2:0], 3'b000} +: 8] = b;
          end
          if (cur.entry_type == madt_pkg::TYPE_IOAPIC && eo >= 8'd8 && eo < 8'd12) begin
            nx.field_interrupt[{eo[1:0], 3'b000} +: 8] = b;
          end
          if (cur.entry_type == madt_pkg::TYPE_OVERRIDE && eo >= 8'd4 && eo < 8'd8) begin
            nx.field_interrupt[{eo[1:0], 3'b000} +: 8] = b;
          end
        end

        if (!malformed) begin
          if (eo != 8'd0 && ({1'b0, eo} + 9'd1) == {1'b0, nx.entry_length}) begin
            unique case (nx.entry_type)
              madt_pkg::TYPE_PROCESSOR: begin
                ent_hit             = 1'b1;
                ent_rec.record_kind = madt_pkg::KIND_PROCESSOR;
                ent_rec.ordinal     = nx.processor_count;
                ent_rec.first_id    = nx.field_a;
                ent_rec.second_id   = nx.field_b;
                nx.processor_count  = madt_pkg::sat_inc(nx.processor_count);
              end
              madt_pkg::TYPE_IOAPIC: begin
                ent_hit             = 1'b1;
                ent_rec.record_kind = madt_pkg::KIND_IOAPIC;
                ent_rec.ordinal     = nx.ioapic_total;
                ent_rec.first_id    = nx.field_a;
                ent_rec.address     = {32'd0, nx.field_address[31:0]};
                ent_rec.gsi         = nx.field_interrupt;
                nx.ioapic_total     = madt_pkg::sat_inc(nx.ioapic_total);
              end
              madt_pkg::TYPE_OVERRIDE: begin
                ent_hit             = 1'b1;
                ent_rec.record_kind = madt_pkg::KIND_OVERRIDE;
                ent_rec.ordinal     = nx.override_count;
                ent_rec.first_id    = nx.field_b;
                ent_rec.second_id   = nx.field_a;
                ent_rec.gsi         = nx.field_interrupt;
                nx.override_count   = madt_pkg::sat_inc(nx.override_count);
              end
              madt_pkg::TYPE_LAPIC_ADDRESS: begin
                if (!nx.base_replaced) begin
                  nx.local_apic_base = nx.field_address;
                  nx.base_replaced   = 1'b1;
                end
              end
              default: begin
              end
            endcase
            nx.entry_offset = '0;
          end else begin
            nx.entry_offset = eo + 8'd1;
          end
        end
      end

      if (malformed) begin
        // The parse stops here; no done record and no offset advance.
        nx.halted         = 1'b1;
        rec0.record_kind  = madt_pkg::KIND_MALFORMED;
        rec0.first_id     = nx.entry_type;
        rec0.second_id    = b;
        rec0.last_of_run  = 1'b1;
        rec_count         = 2'd1;
      end else begin
        done_rec.record_kind = madt_pkg::KIND_DONE;
        done_rec.ordinal     = nx.override_count;
        done_rec.first_id    = nx.processor_count;
        done_rec.second_id   = nx.ioapic_total;
        done_rec.address     = nx.local_apic_base;
        done_rec.last_of_run = 1'b1;
        if (p >= (madt_pkg::HDR_LEN - 1) &&
            ({1'b0, p} + 33'd1) >= {1'b0, cur.table_length}) begin
          nx.halted = 1'b1;
          if (ent_hit) begin
            rec0      = ent_rec;
            rec1      = done_rec;
            rec_count = 2'd2;
          end else begin
            rec0      = done_rec;
            rec_count = 2'd1;
          end
        end else if (ent_hit) begin
          rec0             = ent_rec;
          rec0.last_of_run = 1'b1;
          rec_count        = 2'd1;
        end
        if (p != 32'hFFFF_FFFF) begin
          nx.byte_offset = p + 32'd1;
        end
      end
    end

    st_next = nx;
  end

endmodule

FILE: design/madt_rec_fifo.sv
// Small record queue that takes up to two records per cycle and hands out one.
// Depends on madt_pkg for the record type and queue geometry.
module madt_rec_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  madt_pkg::record_t push_data0,
  input  madt_pkg::record_t push_data1,
  output logic              room,
  output logic              valid,
  input  logic              ready,
  output madt_pkg::record_t data
);

  madt_pkg::record_t                 slots [madt_pkg::REC_DEPTH];
  logic [madt_pkg::REC_PTR_W-1:0]    wr_ptr;
  logic [madt_pkg::REC_PTR_W-1:0]    rd_ptr;
  logic [madt_pkg::REC_CNT_W-1:0]    count;
  logic [madt_pkg::REC_PTR_W-1:0]    wr_ptr_1;
  logic                              pop;

  assign valid    = (count != '0);
  assign data     = slots[rd_ptr];
  assign pop      = valid && ready;
  assign wr_ptr_1 = wr_ptr + 1'b1;
  // Room is kept for the two records that one byte can cause.
  assign room     = (count <= madt_pkg::REC_CNT_W'(madt_pkg::REC_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push_data0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr_1] <= push_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + madt_pkg::REC_PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + madt_pkg::REC_CNT_W'(push_count)
                     - madt_pkg::REC_CNT_W'(pop);
    end
  end

endmodule

FILE: design/madt_table_parser_core.sv
// Top level of the multiple-APIC description table parser.
// Depends on madt_pkg, madt_step and madt_rec_fifo.
//
//   Channel  Direction  Handshake                     Payload
//   byte     in         byte_valid / byte_ready       byte_data   (madt_pkg::byte_t)
//   record   out        record_valid / record_ready   record_data (madt_pkg::record_t)
//
// One table byte is taken per cycle while the record queue has room for its records.
// The record queue holds four entries and takes a byte only while two places are free,
// so a stalled output throttles input after three to four queued records.
// A byte that ends both an entry and the table gives two records, which leave the queue
// one after the other. Reset is synchronous and leaves the parser waiting for a first byte.
module madt_table_parser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  madt_pkg::byte_t   byte_data,
  output logic              record_valid,
  input  logic              record_ready,
  output madt_pkg::record_t record_data
);

  madt_pkg::parse_state_t st;
  madt_pkg::parse_state_t st_next;
  madt_pkg::record_t      rec0;
  madt_pkg::record_t      rec1;
  logic [1:0]             rec_count;
  logic                   room;
  logic                   take;

  // A transfer on the byte channel needs room for the worst case of two records.
  assign byte_ready = room;
  assign take       = byte_valid && byte_ready;

  madt_step u_step (
    .st        (st),
    .data      (byte_data),
    .st_next   (st_next),
    .rec_count (rec_count),
    .rec0      (rec0),
    .rec1      (rec1)
  );

  // Parse state advances only on an accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= madt_pkg::PARSE_STATE_RESET;
    end else if (take) begin
      st <= st_next;
    end
  end

  madt_rec_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (take ? rec_count : 2'd0),
    .push_data0 (rec0),
    .push_data1 (rec1),
    .room       (room),
    .valid      (record_valid),
    .ready      (record_ready),
    .data       (record_data)
  );

endmodule
